// ===== rtl/core/fba_pkg.sv =====
// Shared types, sizes, request codes and the ffz helper function for the frame bitmap allocator.
// It depends on nothing else. Every other file in rtl/core but fba_ram imports it.
package fba_pkg;

  localparam int NUM_FRAMES = 1048576;
  localparam int WORD_BITS  = 32;
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int COUNT_W    = FRAME_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);

  // Summary hierarchy: L0 bitmap words, L1 full flags per L0 word,
  // L2 full flags per L1 word, L3 full flags per L2 word.
  localparam int L0_DEPTH = NUM_FRAMES / WORD_BITS;
  localparam int L1_DEPTH = L0_DEPTH / WORD_BITS;
  localparam int L2_DEPTH = L1_DEPTH / WORD_BITS;
  localparam int L0_AW    = $clog2(L0_DEPTH);
  localparam int L1_AW    = $clog2(L1_DEPTH);
  localparam int L2_AW    = $clog2(L2_DEPTH);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [1:0]           req_t;

  localparam req_t REQ_ALLOC = 2'd0;
  localparam req_t REQ_MARK  = 2'd1;
  localparam req_t REQ_FREE  = 2'd2;
  localparam req_t REQ_QUERY = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOF = 1'b1;

  localparam count_t TOTAL_RESET = count_t'(NUM_FRAMES);
  localparam count_t COUNT_MAX   = '1;

  typedef struct packed {
    logic              we;
    logic [L0_AW-1:0]  waddr;
    word_t             wdata;
    logic              re;
    logic [L0_AW-1:0]  raddr;
  } l0_req_t;

  typedef struct packed {
    logic              we;
    logic [L1_AW-1:0]  waddr;
    word_t             wdata;
    logic              re;
    logic [L1_AW-1:0]  raddr;
  } l1_req_t;

  // lowest clear bit of a word; all ones returns the top index
  function automatic logic [BIT_W-1:0] ffz(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '1;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/fba_if.sv =====
// Request and response channel interfaces for the frame bitmap allocator.
// Depends on fba_pkg for the payload types.
interface fba_req_if;
  import fba_pkg::*;
  logic   valid;
  logic   ready;
  req_t   req_type;
  frame_t frame_number;

  modport source (output valid, req_type, frame_number, input ready);
  modport sink   (input valid, req_type, frame_number, output ready);
endinterface

interface fba_rsp_if;
  import fba_pkg::*;
  logic   valid;
  logic   ready;
  frame_t result_frame;
  logic   was_used;
  logic   status;
  count_t used_frames;

  modport source (output valid, result_frame, was_used, status, used_frames, input ready);
  modport sink   (input valid, result_frame, was_used, status, used_frames, output ready);
endinterface

// ===== rtl/core/frame_bitmap_allocator.sv =====
// Top level of the first-fit page-frame allocator: bitmap RAM, full-flag RAM, sequencer.
// Depends on fba_pkg, fba_if, fba_ram and fba_ctrl.
//
// Requests arrive on in_req (valid/ready), one word per request: allocate lowest
// free frame, mark used, free, or query. Each request returns one word on out_rsp
// with the frame, its previous bit, the status and the used-frame count.
// cfg_we/cfg_wdata write total_frames; write only while no request is in flight.
//
// Frame bits live in a 32768 x 32 RAM; a 1024 x 32 RAM flags full bitmap words,
// and two small register levels flag full RAM words above that, so an allocate
// walks three levels instead of scanning words.
// Mark, free and query: accept, then an update state, result registered; the next
// request is taken only once the update has committed. Allocate adds a fetch state
// for the full-flag RAM read, skipped for an allocate with every frame used.
// Reset: a clearing pass writes every bitmap and full-flag word to zero with
// in_req.ready low; cfg writes are taken meanwhile.
// A stalled out_rsp holds its word; the next request can still be accepted, and
// its update waits in place until the output register frees up.
module frame_bitmap_allocator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  fba_pkg::count_t cfg_wdata,
  fba_req_if.sink         in_req,
  fba_rsp_if.source       out_rsp
);
  import fba_pkg::*;

  l0_req_t l0_req;
  l1_req_t l1_req;
  word_t   l0_rdata;
  word_t   l1_rdata;

  fba_ram #(.DEPTH(L0_DEPTH), .WIDTH(WORD_BITS)) u_l0_ram (
    .clk   (clk),
    .we    (l0_req.we),
    .waddr (l0_req.waddr),
    .wdata (l0_req.wdata),
    .re    (l0_req.re),
    .raddr (l0_req.raddr),
    .rdata (l0_rdata)
  );

  fba_ram #(.DEPTH(L1_DEPTH), .WIDTH(WORD_BITS)) u_l1_ram (
    .clk   (clk),
    .we    (l1_req.we),
    .waddr (l1_req.waddr),
    .wdata (l1_req.wdata),
    .re    (l1_req.re),
    .raddr (l1_req.raddr),
    .rdata (l1_rdata)
  );

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .l0_req    (l0_req),
    .l0_rdata  (l0_rdata),
    .l1_req    (l1_req),
    .l1_rdata  (l1_rdata)
  );

endmodule

// ===== rtl/core/fba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds until the next read. No package dependency.
module fba_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fba_ctrl.sv =====
// Request sequencer: clearing pass, summary flags, read-modify-write of the
// bitmap and full-flag RAMs, used counter and output register. Uses fba_pkg, fba_if.
module fba_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  fba_pkg::count_t        cfg_wdata,
  fba_req_if.sink                in_req,
  fba_rsp_if.source              out_rsp,
  output fba_pkg::l0_req_t       l0_req,
  input  fba_pkg::word_t         l0_rdata,
  output fba_pkg::l1_req_t       l1_req,
  input  fba_pkg::word_t         l1_rdata
);
  import fba_pkg::*;

  localparam logic [1:0] ST_CLR   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [L0_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  frame_t           frm_r, frm_nxt;
  req_t             req_r, req_nxt;
  logic             oof_r, oof_nxt;
  count_t           total_r;
  count_t           used_r, used_nxt;
  word_t            l3_r;
  word_t            l2_r [L2_DEPTH];

  logic             out_valid_r, out_valid_nxt;
  frame_t           out_frame_r;
  logic             out_was_r;
  logic             out_status_r;
  count_t           out_used_r;

  logic             out_free, accept, commit;
  logic [BIT_W-1:0] i2_alloc, b2_alloc, bsel;
  logic             l3_full;
  frame_t           f;
  logic             was, set_op, clr_op, is_alloc, in_range, alloc_fail, changed;
  word_t            m0, m1, m2, m3, l0_new, l1_new, l2_cur, l2_new;
  logic [L2_AW-1:0] l2i;
  logic             l1_we, l2_we, l3_we;

  assign out_free = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == ST_IDLE);
  assign accept = in_req.valid && in_req.ready;
  assign commit = (state_r == ST_UPD) && out_free;

  assign l3_full  = &l3_r;
  assign i2_alloc = ffz(l3_r);
  assign b2_alloc = ffz(l2_r[i2_alloc]);

  // update step, works on held RAM read data
  always_comb begin
    is_alloc   = (req_r == REQ_ALLOC);
    set_op     = (req_r == REQ_ALLOC) || (req_r == REQ_MARK);
    clr_op     = (req_r == REQ_FREE);
    bsel       = is_alloc ? ffz(l0_rdata) : frm_r[BIT_W-1:0];
    f          = {frm_r[FRAME_W-1:BIT_W], bsel};
    was        = l0_rdata[bsel];
    in_range   = {1'b0, f} < total_r;
    alloc_fail = oof_r || (is_alloc && !in_range);
    changed    = !alloc_fail && ((set_op && !was) || (clr_op && was));
    m0         = word_t'(1) << bsel;
    m1         = word_t'(1) << f[2*BIT_W-1:BIT_W];
    m2         = word_t'(1) << f[3*BIT_W-1:2*BIT_W];
    m3         = word_t'(1) << f[FRAME_W-1:3*BIT_W];
    l2i        = f[FRAME_W-1:FRAME_W-L2_AW];
    l2_cur     = l2_r[l2i];
    l0_new     = set_op ? (l0_rdata | m0) : (l0_rdata & ~m0);
    l1_new     = set_op ? (l1_rdata | m1) : (l1_rdata & ~m1);
    l2_new     = set_op ? (l2_cur | m2) : (l2_cur & ~m2);
    l1_we      = commit && changed && (clr_op || (&l0_new));
    l2_we      = commit && changed && (clr_op || ((&l0_new) && (&l1_new)));
    l3_we      = commit && changed && (clr_op || ((&l0_new) && (&l1_new) && (&l2_new)));
    used_nxt   = used_r;
    if (changed && in_range) begin
      if (set_op) begin
        if (used_r != COUNT_MAX) used_nxt = used_r + count_t'(1);
      end else begin
        if (used_r != '0) used_nxt = used_r - count_t'(1);
      end
    end
  end

  // RAM requests
  always_comb begin
    l0_req = '0;
    l1_req = '0;
    if (state_r == ST_CLR) begin
      l0_req.we    = 1'b1;
      l0_req.waddr = clr_cnt_r;
      l1_req.we    = (clr_cnt_r[L0_AW-1:L1_AW] == '0);
      l1_req.waddr = clr_cnt_r[L1_AW-1:0];
    end else begin
      l0_req.we    = commit && changed;
      l0_req.waddr = f[FRAME_W-1:BIT_W];
      l0_req.wdata = l0_new;
      l1_req.we    = l1_we;
      l1_req.waddr = f[FRAME_W-1:2*BIT_W];
      l1_req.wdata = l1_new;
    end
    if (accept) begin
      if (in_req.req_type == REQ_ALLOC) begin
        l1_req.re    = !l3_full;
        l1_req.raddr = {i2_alloc, b2_alloc};
      end else begin
        l0_req.re    = 1'b1;
        l0_req.raddr = in_req.frame_number[FRAME_W-1:BIT_W];
        l1_req.re    = 1'b1;
        l1_req.raddr = in_req.frame_number[FRAME_W-1:2*BIT_W];
      end
    end else if (state_r == ST_FETCH) begin
      l0_req.re    = 1'b1;
      l0_req.raddr = {frm_r[FRAME_W-1:2*BIT_W], ffz(l1_rdata)};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    frm_nxt       = frm_r;
    req_nxt       = req_r;
    oof_nxt       = oof_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    unique case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req.req_type;
          if (in_req.req_type == REQ_ALLOC) begin
            frm_nxt   = {i2_alloc, b2_alloc, {(2*BIT_W){1'b0}}};
            oof_nxt   = l3_full;
            state_nxt = l3_full ? ST_UPD : ST_FETCH;
          end else begin
            frm_nxt   = in_req.frame_number;
            oof_nxt   = 1'b0;
            state_nxt = ST_UPD;
          end
        end
      end
      ST_FETCH: begin
        frm_nxt   = {frm_r[FRAME_W-1:2*BIT_W], ffz(l1_rdata), frm_r[BIT_W-1:0]};
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      oof_r       <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      total_r     <= TOTAL_RESET;
      l3_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      oof_r       <= oof_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) used_r <= used_nxt;
      if (cfg_we) total_r <= cfg_wdata;
      if (l3_we) l3_r <= set_op ? (l3_r | m3) : (l3_r & ~m3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L2_DEPTH; i++) l2_r[i] <= '0;
    end else if (l2_we) begin
      l2_r[l2i] <= l2_new;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
    req_r <= req_nxt;
    if (commit) begin
      out_frame_r  <= alloc_fail ? '0 : f;
      out_was_r    <= alloc_fail ? 1'b0 : was;
      out_status_r <= alloc_fail ? STATUS_OOF : STATUS_OK;
      out_used_r   <= used_nxt;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_frame = out_frame_r;
  assign out_rsp.was_used     = out_was_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.used_frames  = out_used_r;

endmodule

// ===== rtl/core/fba_checker.sv =====
// Port-level checks for frame_bitmap_allocator, attached by bind.
// Depends on fba_pkg and the top level's ports.
module fba_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input fba_pkg::frame_t out_result_frame,
  input logic            out_was_used,
  input logic            out_status,
  input fba_pkg::count_t out_used_frames
);
  import fba_pkg::*;

  // reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_oof_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_OOF) |-> (out_result_frame == '0 && !out_was_used))
    else $error("out-of-frames word carries a frame");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_frame) &&
      $stable(out_was_used) && $stable(out_status) && $stable(out_used_frames)))
    else $error("stalled response word changed");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_result_frame (out_rsp.result_frame),
  .out_was_used     (out_rsp.was_used),
  .out_status       (out_rsp.status),
  .out_used_frames  (out_rsp.used_frames)
);
